### rtl/pdsrch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PLL divider search package
// Shared widths, search limits, register indexes and the divider
// request/response types.
// ----------------------------------------------------------------------------
package pdsrch_pkg;

  localparam int unsigned PREDIV_MAX   = 32;
  localparam int unsigned MULT_MIN     = 6;
  localparam int unsigned MULT_MAX     = 512;
  localparam int unsigned CORE_DIV_MAX = 256;

  localparam int unsigned NUM_W = 36;  // 2*mult*crystal
  localparam int unsigned DEN_W = 29;  // target + 1
  localparam int unsigned Q_W   = 30;  // every quotient fits below 2^30
  localparam int unsigned DIV_STEPS = Q_W / 2;  // radix-4, two bits a cycle

  // configuration register indexes and reset values
  localparam logic        CFG_VCO_MIN   = 1'b0;
  localparam logic        CFG_VCO_MAX   = 1'b1;
  localparam logic [29:0] VCO_MIN_RESET = 30'd275_000_000;
  localparam logic [29:0] VCO_MAX_RESET = 30'd550_000_000;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/pll_divider_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PLL divider search
// Finds pre-divider, multiplier and core divider giving the highest core
// clock not above the target, with the oscillator inside the set window.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | crystal_hz, target_hz
//  out     | out_valid / out_ready| found, pre_div, best_mult,
//          |                      | best_core_div, achieved_hz
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One item at a time. Each of the 32 x 507 divider pairs needs no division
// when outside the window, two divisions when the core divider would exceed
// its limit and three otherwise, all on the shared radix-4 divider (15 digit
// steps per division). The window test is a compare against min*p and
// (max+1)*p, no division. Reset is synchronous; no clearing pass. A held
// result does not block the next item; a finished search waits only if the
// result is still held.
// ----------------------------------------------------------------------------
module pll_divider_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [29:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [24:0] in_crystal_hz,
  input  wire logic [27:0] in_target_hz,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [5:0]       out_pre_div,
  output logic [9:0]       out_best_mult,
  output logic [8:0]       out_best_core_div,
  output logic [27:0]      out_achieved_hz
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_DIV1  = 7'b0000100,
    S_DIV2  = 7'b0001000,
    S_DIV3  = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [29:0] vmin_r, vmax_r;
  logic [24:0] crystal_r, crystal_nxt;
  logic [27:0] target_r, target_nxt;
  logic [5:0]  p_r, p_nxt;
  logic [9:0]  m_r, m_nxt;
  logic [35:0] num_r, num_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [29:0] fcco_r, fcco_nxt;
  logic [8:0]  d_r, d_nxt;
  logic [5:0]  bp_r, bp_nxt;
  logic [9:0]  bm_r, bm_nxt;
  logic [8:0]  bd_r, bd_nxt;
  logic [27:0] bf_r, bf_nxt;
  logic        ov_r, ov_nxt;
  logic        of_r;
  logic [5:0]  op_r;
  logic [9:0]  om_r;
  logic [8:0]  od_r;
  logic [27:0] oa_r;
  logic        load_out;

  pdsrch_pkg::div_req_t dreq;
  pdsrch_pkg::div_rsp_t drsp;

  pdsrch_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    state_nxt   = state_r;
    crystal_nxt = crystal_r;
    target_nxt  = target_r;
    p_nxt       = p_r;
    m_nxt       = m_r;
    num_nxt     = num_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    fcco_nxt    = fcco_r;
    d_nxt       = d_r;
    bp_nxt      = bp_r;
    bm_nxt      = bm_r;
    bd_nxt      = bd_r;
    bf_nxt      = bf_r;
    load_out    = 1'b0;
    dreq.start  = 1'b0;
    dreq.num    = num_r;
    dreq.den    = pdsrch_pkg::DEN_W'(p_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          crystal_nxt = in_crystal_hz;
          target_nxt  = in_target_hz;
          p_nxt       = 6'd1;
          m_nxt       = 10'(pdsrch_pkg::MULT_MIN);
          num_nxt     = 36'({in_crystal_hz, 3'b000}) + 36'({in_crystal_hz, 2'b00});
          lo_nxt      = 36'(vmin_r);
          hi_nxt      = 36'(vmax_r) + 36'd1;
          bp_nxt      = '0;
          bm_nxt      = '0;
          bd_nxt      = '0;
          bf_nxt      = '0;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (num_r >= lo_r && num_r < hi_r) begin
          dreq.start = 1'b1;
          state_nxt  = S_DIV1;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV1: begin
        if (drsp.done) begin
          fcco_nxt   = drsp.quo;
          dreq.start = 1'b1;
          dreq.num   = 36'(drsp.quo);
          dreq.den   = 29'(target_r) + 29'd1;
          state_nxt  = S_DIV2;
        end
      end
      S_DIV2: begin
        if (drsp.done) begin
          // divider above the limit: drop this pair
          if (drsp.quo >= 30'(pdsrch_pkg::CORE_DIV_MAX)) begin
            state_nxt = S_NEXT;
          end else begin
            d_nxt      = 9'(drsp.quo) + 9'd1;
            dreq.start = 1'b1;
            dreq.num   = 36'(fcco_r);
            dreq.den   = 29'(9'(drsp.quo) + 9'd1);
            state_nxt  = S_DIV3;
          end
        end
      end
      S_DIV3: begin
        if (drsp.done) begin
          if (drsp.quo > 30'(bf_r)) begin
            bf_nxt = 28'(drsp.quo);
            bp_nxt = p_r;
            bm_nxt = m_r;
            bd_nxt = d_r;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (m_r == 10'(pdsrch_pkg::MULT_MAX)) begin
          if (p_r == 6'(pdsrch_pkg::PREDIV_MAX)) begin
            state_nxt = S_FIN;
          end else begin
            p_nxt     = p_r + 6'd1;
            m_nxt     = 10'(pdsrch_pkg::MULT_MIN);
            num_nxt   = 36'({crystal_r, 3'b000}) + 36'({crystal_r, 2'b00});
            lo_nxt    = lo_r + 36'(vmin_r);
            hi_nxt    = hi_r + 36'(vmax_r) + 36'd1;
            state_nxt = S_CHECK;
          end
        end else begin
          m_nxt     = m_r + 10'd1;
          num_nxt   = num_r + 36'({crystal_r, 1'b0});
          state_nxt = S_CHECK;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if (load_out)  ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      vmin_r  <= pdsrch_pkg::VCO_MIN_RESET;
      vmax_r  <= pdsrch_pkg::VCO_MAX_RESET;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        if (cfg_index == pdsrch_pkg::CFG_VCO_MIN) vmin_r <= cfg_data;
        else                                      vmax_r <= cfg_data;
      end
    end
    crystal_r <= crystal_nxt;
    target_r  <= target_nxt;
    p_r       <= p_nxt;
    m_r       <= m_nxt;
    num_r     <= num_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    fcco_r    <= fcco_nxt;
    d_r       <= d_nxt;
    bp_r      <= bp_nxt;
    bm_r      <= bm_nxt;
    bd_r      <= bd_nxt;
    bf_r      <= bf_nxt;
    if (load_out) begin
      of_r <= bf_r != 28'd0;
      op_r <= bp_r;
      om_r <= bm_r;
      od_r <= bd_r;
      oa_r <= bf_r;
    end
  end

  assign in_ready          = state_r == S_IDLE;
  assign out_valid         = ov_r;
  assign out_found         = of_r;
  assign out_pre_div       = op_r;
  assign out_best_mult     = om_r;
  assign out_best_core_div = od_r;
  assign out_achieved_hz   = oa_r;

endmodule
`default_nettype wire

### rtl/pdsrch_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PLL divider search: serial divider
// Radix-4 restoring divider, two quotient bits per cycle. The quotient must
// fit in Q_W bits, i.e. num < den * 2^Q_W.
// ----------------------------------------------------------------------------
module pdsrch_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pdsrch_pkg::div_req_t req,
  output pdsrch_pkg::div_rsp_t     rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [3:0]                   cnt_r, cnt_nxt;
  logic [pdsrch_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [pdsrch_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [pdsrch_pkg::Q_W-1:0]   nl_r, nl_nxt;
  logic [pdsrch_pkg::Q_W-1:0]   q_r, q_nxt;

  logic [pdsrch_pkg::DEN_W:0]   t1, t2;
  logic [pdsrch_pkg::DEN_W-1:0] r1, r2;
  logic                         ge1, ge2;

  always_comb begin
    t1  = {rem_r, nl_r[pdsrch_pkg::Q_W-1]};
    ge1 = t1 >= {1'b0, den_r};
    r1  = ge1 ? pdsrch_pkg::DEN_W'(t1 - {1'b0, den_r}) : pdsrch_pkg::DEN_W'(t1);
    t2  = {r1, nl_r[pdsrch_pkg::Q_W-2]};
    ge2 = t2 >= {1'b0, den_r};
    r2  = ge2 ? pdsrch_pkg::DEN_W'(t2 - {1'b0, den_r}) : pdsrch_pkg::DEN_W'(t2);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    nl_nxt   = nl_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = req.den;
      rem_nxt  = pdsrch_pkg::DEN_W'(req.num[pdsrch_pkg::NUM_W-1:pdsrch_pkg::Q_W]);
      nl_nxt   = req.num[pdsrch_pkg::Q_W-1:0];
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = r2;
      nl_nxt  = {nl_r[pdsrch_pkg::Q_W-3:0], 2'b00};
      q_nxt   = {q_r[pdsrch_pkg::Q_W-3:0], ge1, ge2};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(pdsrch_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    nl_r  <= nl_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule
`default_nettype wire

### rtl/pdsrch_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PLL divider search checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pdsrch_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_found,
  input wire logic [5:0]  out_pre_div,
  input wire logic [9:0]  out_best_mult,
  input wire logic [8:0]  out_best_core_div,
  input wire logic [27:0] out_achieved_hz
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_found_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_found == (out_achieved_hz != 28'd0))
    else $error("found flag disagrees with frequency");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_pre_div == 6'd0 && out_best_mult == 10'd0
      && out_best_core_div == 9'd0) else $error("settings not cleared");

  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_pre_div != 6'd0 && out_pre_div <= 6'd32
      && out_best_mult >= 10'd6 && out_best_core_div != 9'd0
      && out_best_core_div <= 9'd256) else $error("setting out of range");

endmodule

bind pll_divider_search pdsrch_checker u_pdsrch_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_found(out_found), .out_pre_div(out_pre_div),
  .out_best_mult(out_best_mult), .out_best_core_div(out_best_core_div),
  .out_achieved_hz(out_achieved_hz)
);
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search testbench
// Drives crystal/target requests through the search block under several
// oscillator windows and checks each returned setting against an exhaustive
// in-bench search over every pre-divider and multiplier.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [29:0] VCO_TOP = 30'h3FFF_FFFF;

  typedef struct packed {
    logic        found;
    logic [5:0]  prediv;
    logic [9:0]  mult;
    logic [8:0]  core_div;
    logic [27:0] achieved;
  } pll_setting_t;

  class divider_scoreboard;
    longint unsigned vco_lo = pdsrch_pkg::VCO_MIN_RESET;
    longint unsigned vco_hi = pdsrch_pkg::VCO_MAX_RESET;
    pll_setting_t pending_settings[$];
    int mismatches = 0;

    function pll_setting_t best_setting(logic [24:0] crystal, logic [27:0] target);
      pll_setting_t s;
      longint unsigned fcco, d, core, best_f;
      s = '0;
      best_f = 0;
      for (int p = 1; p <= pdsrch_pkg::PREDIV_MAX; p++) begin
        for (int m = pdsrch_pkg::MULT_MIN; m <= pdsrch_pkg::MULT_MAX; m++) begin
          fcco = (64'd2 * m * crystal) / p;
          if (fcco < vco_lo || fcco > vco_hi) continue;
          // smallest divider that lands at or below the target
          d = fcco / (longint'(target) + 1) + 1;
          if (d > pdsrch_pkg::CORE_DIV_MAX) continue;
          core = fcco / d;
          if (core > best_f) begin
            best_f = core;
            s.prediv = 6'(p);
            s.mult = 10'(m);
            s.core_div = 9'(d);
            s.achieved = 28'(core);
          end
        end
      end
      s.found = (best_f != 0);
      return s;
    endfunction

    function void note_request(logic [24:0] crystal, logic [27:0] target);
      pending_settings.push_back(best_setting(crystal, target));
    endfunction

    function void check_result(pll_setting_t got);
      pll_setting_t want;
      if (pending_settings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_settings.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [29:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [24:0] in_crystal_hz;
  logic [27:0] in_target_hz;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic [5:0]  out_pre_div;
  logic [9:0]  out_best_mult;
  logic [8:0]  out_best_core_div;
  logic [27:0] out_achieved_hz;

  divider_scoreboard sb = new();
  bit ready_steady = 0;
  int ready_hold = 0;

  pll_divider_search DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 200);
  endfunction

  // receiver: stall in bursts unless a steady stretch is on
  always @(negedge clk) begin
    if (ready_steady) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_found, out_pre_div, out_best_mult,
                       out_best_core_div, out_achieved_hz});
  end

  task automatic send_request(logic [24:0] crystal, logic [27:0] target, bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_crystal_hz <= crystal;
    in_target_hz <= target;
    do @(posedge clk); while (!in_ready);
    sb.note_request(crystal, target);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_settings.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(logic [29:0] lo, logic [29:0] hi);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= pdsrch_pkg::CFG_VCO_MIN;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= pdsrch_pkg::CFG_VCO_MAX;
    cfg_data <= hi;
    sb.vco_lo = lo;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.vco_hi = hi;
  endtask

  initial begin
    longint unsigned f, span, lo, hi;
    int c0;
    logic [24:0] c;
    logic [27:0] t;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = pdsrch_pkg::CFG_VCO_MIN;
    cfg_data = '0;
    in_valid = 0;
    in_crystal_hz = '0;
    in_target_hz = '0;
    out_ready = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset window first
    send_request(25'd12_000_000, 28'd100_000_000, 0);
    send_request(25'd12_000_000, 28'd72_000_000, 1);  // exact hit
    send_request(25'd0, 28'd100_000_000, 0);
    send_request(25'd12_000_000, 28'd0, 1);
    send_request(25'h1FF_FFFF, 28'hFFF_FFFF, 0);
    send_request(25'd1, 28'd1, 0);
    send_request(25'd30_000_000, 28'd200_000_000, 0);
    send_request(25'd4_000_000, 28'd1_000_000, 0);
    drain();

    set_window(30'd400_000_000, 30'd300_000_000);  // inverted
    send_request(25'd12_000_000, 28'd100_000_000, 0);
    drain();
    set_window(30'd288_000_000, 30'd288_000_000);  // single point
    send_request(25'd12_000_000, 28'd100_000_000, 0);
    send_request(25'd12_000_000, 28'd72_000_000, 0);
    drain();
    set_window(30'd0, VCO_TOP);  // widest window the 30-bit registers hold
    send_request(25'd12_000_000, 28'd123_456_789, 0);
    send_request(25'h1FF_FFFF, 28'd200_000_000, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      c0 = $urandom_range(1, 30_000_000);
      f = (64'd2 * $urandom_range(pdsrch_pkg::MULT_MIN, pdsrch_pkg::MULT_MAX) * c0)
          / $urandom_range(1, pdsrch_pkg::PREDIV_MAX);
      if (f > VCO_TOP) f = VCO_TOP;
      span = f >> $urandom_range(3, 9);
      lo = f - span;
      hi = (f + span > VCO_TOP) ? VCO_TOP : f + span;
      set_window(30'(lo), 30'(hi));
      ready_steady = (ph % 4 == 3);
      repeat (9) begin
        case ($urandom_range(0, 9))
          0: begin
            c = 25'($urandom);
            t = 28'($urandom);
          end
          1, 2: begin
            c = 25'($urandom_range(1, 30_000_000));
            t = 28'($urandom_range(1, 200_000_000));
          end
          default: begin
            c = 25'(c0 + $urandom_range(0, c0 >> 6));
            t = 28'($urandom_range(1, 200_000_000));
          end
        endcase
        send_request(c, t, ph % 3 == 1);
      end
      drain();
    end

    ready_steady = 0;
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_settings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(64'd6_000_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
